// ===== rtl/ofc_pkg.sv =====
package ofc_pkg;

  localparam int NUM_PLANES_DEF = 6;
  localparam int PLANE_W        = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  localparam int COORD_W  = 24;
  localparam int AXIS_W   = 36;
  localparam int COMP_W   = 12;
  localparam int EXTENT_W = 23;
  localparam int DIST_W   = 28;

  // internal widths, all exact
  localparam int PC_W    = COMP_W + COORD_W;   // normal * center
  localparam int PA_W    = 2 * COMP_W;         // normal * axis component
  localparam int D_W     = PC_W + 3;           // plane distance, Q.18
  localparam int DOT_W   = PA_W + 2;           // signed dot product
  localparam int ABS_W   = PA_W + 1;           // |dot|
  localparam int RP_W    = ABS_W + EXTENT_W;   // |dot| * extent
  localparam int R_W     = RP_W + 2;           // projected radius, Q.28
  localparam int CMP_W   = R_W + 2;            // d +/- r
  localparam int D_SHIFT = 10;

  localparam logic [1:0] POS_INSIDE  = 2'd0;
  localparam logic [1:0] POS_SPAN    = 2'd1;
  localparam logic [1:0] POS_OUTSIDE = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [AXIS_W-1:0]         axis_0;
    logic [AXIS_W-1:0]         axis_1;
    logic [AXIS_W-1:0]         axis_2;
    logic [EXTENT_W-1:0]       extent_0;
    logic [EXTENT_W-1:0]       extent_1;
    logic [EXTENT_W-1:0]       extent_2;
  } in_word_t;

  typedef struct packed {
    logic [1:0] position;
    logic       visible;
  } out_word_t;

  typedef struct packed {
    logic outside;
    logic span;
    logic hidden;
  } flags_t;

  typedef struct packed {
    in_word_t box;
    flags_t   flags;
  } item_t;

endpackage

// ===== rtl/obb_frustum_cull_test.sv =====
// Oriented box versus frustum cull test. Each word carries a box (center,
// three unit axes, three half extents) and returns one word with the position
// (inside, spanning, outside) and the visible flag, tested against NUM_PLANES
// planes written through the cfg_ port (index i writes plane i, other indices
// are dropped; all planes reset to zero, which makes every box spanning and not
// visible). The planes form a row of cells, one per plane; each cell is a
// five-stage pipeline (products, sums and abs, radius products, radius sum,
// compare), and a new box is taken every cycle while out_stall is low. Empty
// stages close up while out_stall holds, so input is taken until every stage
// is full. Write the planes only while no box is in flight.
module obb_frustum_cull_test #(
  parameter int NUM_PLANES = ofc_pkg::NUM_PLANES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ofc_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ofc_pkg::out_word_t             out_word,
  input  logic                           cfg_we,
  input  logic [ofc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ofc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [ofc_pkg::PLANE_W-1:0] plane_r [NUM_PLANES];

  logic                        c_valid [NUM_PLANES+1];
  logic                        c_ready [NUM_PLANES+1];
  ofc_pkg::item_t              c_item  [NUM_PLANES+1];
  ofc_pkg::flags_t             fl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_r[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        if (cfg_we && cfg_index == ofc_pkg::CFG_IDX_W'(p)) begin
          plane_r[p] <= cfg_data[ofc_pkg::PLANE_W-1:0];
        end
      end
    end
  end

  assign c_valid[0]     = in_valid;
  assign c_item[0]      = '{box: in_word, flags: '0};
  assign in_stall       = !c_ready[0];

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    ofc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .plane    (plane_r[p]),
      .up_valid (c_valid[p]),
      .up_item  (c_item[p]),
      .up_ready (c_ready[p]),
      .dn_valid (c_valid[p+1]),
      .dn_item  (c_item[p+1]),
      .dn_ready (c_ready[p+1])
    );
  end

  assign c_ready[NUM_PLANES] = !out_stall;
  assign out_valid           = c_valid[NUM_PLANES];
  assign fl                  = c_item[NUM_PLANES].flags;

  always_comb begin
    if (fl.outside) begin
      out_word.position = ofc_pkg::POS_OUTSIDE;
    end else if (fl.span) begin
      out_word.position = ofc_pkg::POS_SPAN;
    end else begin
      out_word.position = ofc_pkg::POS_INSIDE;
    end
    out_word.visible = !fl.hidden;
  end

  a_inside_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.position == ofc_pkg::POS_INSIDE |-> out_word.visible)
    else $error("inside box reported not visible");

  a_outside_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.position == ofc_pkg::POS_OUTSIDE |-> !out_word.visible)
    else $error("outside box reported visible");

  a_hidden_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.visible |-> out_word.position != ofc_pkg::POS_INSIDE)
    else $error("hidden box reported inside");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present right after reset");

endmodule

// ===== rtl/ofc_cell.sv =====
module ofc_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ofc_pkg::PLANE_W-1:0] plane,
  input  logic                        up_valid,
  input  ofc_pkg::item_t              up_item,
  output logic                        up_ready,
  output logic                        dn_valid,
  output ofc_pkg::item_t              dn_item,
  input  logic                        dn_ready
);

  localparam int CW = ofc_pkg::COMP_W;

  logic signed [CW-1:0]                 n [3];
  logic signed [ofc_pkg::DIST_W-1:0]    dd;
  logic signed [ofc_pkg::COORD_W-1:0]   cen [3];
  logic [ofc_pkg::AXIS_W-1:0]           axw [3];
  logic [ofc_pkg::EXTENT_W-1:0]         ext [3];

  // stage registers
  logic                                 v_r [5];
  ofc_pkg::item_t                       it1_r, it2_r, it3_r, it4_r, it5_r;
  logic signed [ofc_pkg::PC_W-1:0]      pc_r [3];
  logic signed [ofc_pkg::PA_W-1:0]      pa_r [3][3];
  logic signed [ofc_pkg::D_W-1:0]       d2_r, d3_r, d4_r;
  logic [ofc_pkg::ABS_W-1:0]            abs_r [3];
  logic [ofc_pkg::RP_W-1:0]             rp_r [3];
  logic [ofc_pkg::R_W-1:0]              r_r;

  logic                                 en [6];

  logic signed [ofc_pkg::PC_W-1:0]      pc_nxt [3];
  logic signed [ofc_pkg::PA_W-1:0]      pa_nxt [3][3];
  logic signed [ofc_pkg::D_W-1:0]       d_nxt;
  logic [ofc_pkg::ABS_W-1:0]            abs_nxt [3];
  logic [ofc_pkg::RP_W-1:0]             rp_nxt [3];
  logic [ofc_pkg::R_W-1:0]              r_nxt;
  logic signed [ofc_pkg::CMP_W-1:0]     dq, rr, sum_w, dif_w;
  ofc_pkg::flags_t                      flags_nxt;

  assign n[0] = plane[CW-1:0];
  assign n[1] = plane[2*CW-1:CW];
  assign n[2] = plane[3*CW-1:2*CW];
  assign dd   = plane[ofc_pkg::PLANE_W-1:3*CW];

  // center and axes are taken from the incoming box, extents from the box held in stage 2
  assign cen[0] = up_item.box.center_x;
  assign cen[1] = up_item.box.center_y;
  assign cen[2] = up_item.box.center_z;
  assign axw[0] = up_item.box.axis_0;
  assign axw[1] = up_item.box.axis_1;
  assign axw[2] = up_item.box.axis_2;
  assign ext[0] = it2_r.box.extent_0;
  assign ext[1] = it2_r.box.extent_1;
  assign ext[2] = it2_r.box.extent_2;

  // a stage advances when it is empty or the one after it advances
  always_comb begin
    en[5] = dn_ready;
    for (int k = 4; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end
  assign up_ready = en[0];

  always_comb begin
    logic signed [ofc_pkg::DOT_W-1:0] dot;
    logic signed [CW-1:0]             a;
    for (int k = 0; k < 3; k++) begin
      pc_nxt[k] = ofc_pkg::PC_W'(n[k]) * ofc_pkg::PC_W'(cen[k]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        a = axw[i][CW*k +: CW];
        pa_nxt[i][k] = ofc_pkg::PA_W'(n[k]) * ofc_pkg::PA_W'(a);
      end
    end
    d_nxt = ofc_pkg::D_W'(pc_r[0]) + ofc_pkg::D_W'(pc_r[1]) + ofc_pkg::D_W'(pc_r[2])
          + (ofc_pkg::D_W'(dd) <<< ofc_pkg::D_SHIFT);
    for (int i = 0; i < 3; i++) begin
      dot = ofc_pkg::DOT_W'(pa_r[i][0]) + ofc_pkg::DOT_W'(pa_r[i][1])
          + ofc_pkg::DOT_W'(pa_r[i][2]);
      if (dot < 0) begin
        dot = -dot;
      end
      abs_nxt[i] = dot[ofc_pkg::ABS_W-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      rp_nxt[i] = ofc_pkg::RP_W'(abs_r[i]) * ofc_pkg::RP_W'(ext[i]);
    end
    r_nxt = ofc_pkg::R_W'(rp_r[0]) + ofc_pkg::R_W'(rp_r[1]) + ofc_pkg::R_W'(rp_r[2]);
  end

  // compare d, rescaled to Q.28, against the projected radius
  always_comb begin
    dq    = ofc_pkg::CMP_W'(d4_r) <<< ofc_pkg::D_SHIFT;
    rr    = ofc_pkg::CMP_W'(r_r);
    sum_w = dq + rr;
    dif_w = dq - rr;
    flags_nxt         = it4_r.flags;
    flags_nxt.outside = it4_r.flags.outside || sum_w[ofc_pkg::CMP_W-1];
    flags_nxt.hidden  = it4_r.flags.hidden || sum_w[ofc_pkg::CMP_W-1] || (sum_w == '0);
    flags_nxt.span    = it4_r.flags.span || dif_w[ofc_pkg::CMP_W-1] || (dif_w == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < 5; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      it1_r <= up_item;
      pc_r  <= pc_nxt;
      pa_r  <= pa_nxt;
    end
    if (en[1]) begin
      it2_r <= it1_r;
      d2_r  <= d_nxt;
      abs_r <= abs_nxt;
    end
    if (en[2]) begin
      it3_r <= it2_r;
      d3_r  <= d2_r;
      rp_r  <= rp_nxt;
    end
    if (en[3]) begin
      it4_r <= it3_r;
      d4_r  <= d3_r;
      r_r   <= r_nxt;
    end
    if (en[4]) begin
      it5_r <= '{box: it4_r.box, flags: flags_nxt};
    end
  end

  assign dn_valid = v_r[4];
  assign dn_item  = it5_r;

endmodule

// ===== bench/obb_frustum_cull_test_tb.sv =====
`timescale 1ns / 100ps

module obb_frustum_cull_test_tb;

  localparam int NUM_PLANES       = ofc_pkg::NUM_PLANES_DEF;
  localparam int LATENCY          = 5 * NUM_PLANES;
  localparam int RESET_CYCLES     = 11;
  localparam int RANDOM_PER_PHASE = 334;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int CUBE_HALF        = 4096;          // 16.0 in Q15.8
  localparam int COORD_MAX        = 8388607;
  localparam int COORD_MIN        = -8388608;
  localparam int EXT_MAX          = 8388607;
  localparam longint DIST_SCALE   = longint'(1) << ofc_pkg::D_SHIFT;

  localparam logic signed [ofc_pkg::COMP_W-1:0] UNIT_POS  = 12'sd1024;
  localparam logic signed [ofc_pkg::COMP_W-1:0] UNIT_NEG  = -12'sd1024;
  localparam logic signed [ofc_pkg::COMP_W-1:0] DIAG_POS  = 12'sd724;
  localparam logic signed [ofc_pkg::COMP_W-1:0] DIAG_NEG  = -12'sd724;
  localparam logic [ofc_pkg::AXIS_W-1:0] AXIS_X      = 36'h000_000_400;
  localparam logic [ofc_pkg::AXIS_W-1:0] AXIS_Y      = 36'h000_400_000;
  localparam logic [ofc_pkg::AXIS_W-1:0] AXIS_Z      = 36'h400_000_000;
  localparam logic [ofc_pkg::AXIS_W-1:0] AXIS_DIAG_A = 36'h000_2D4_2D4;
  localparam logic [ofc_pkg::AXIS_W-1:0] AXIS_DIAG_B = 36'h000_2D4_D2C;

  typedef enum int {
    REG_NEAR     = 0,
    REG_FAR      = 1,
    REG_RIGHT    = 2,
    REG_LEFT     = 3,
    REG_TOP      = 4,
    REG_BOTTOM   = 5,
    REG_SPARE_LO = 6,
    REG_SPARE_HI = 7
  } plane_reg_e;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  ofc_pkg::in_word_t              in_word   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ofc_pkg::out_word_t             out_word;
  logic                           cfg_we    = 1'b0;
  logic [ofc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ofc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic [ofc_pkg::PLANE_W-1:0] plane_mirror [NUM_PLANES];
  ofc_pkg::in_word_t           pending_box [$];
  ofc_pkg::out_word_t          expected_cull [$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  boxes_queued   = 0;
  int  results_seen   = 0;
  int  error_count    = 0;
  int  plane_writes   = 0;
  int  sent_count     = 0;
  int  drain_holds    = 0;
  int  cycle_count    = 0;
  int  pos_tally [3]  = '{0, 0, 0};
  int  hidden_tally   = 0;
  bit  drain_hold     = 1'b0;
  logic word_taken    = 1'b0;

  obb_frustum_cull_test #(
    .NUM_PLANES(NUM_PLANES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Exact classification of one box against the mirrored planes.
  function automatic ofc_pkg::out_word_t cull_classify(input ofc_pkg::in_word_t box);
    logic signed [ofc_pkg::COORD_W-1:0] cs;
    logic signed [ofc_pkg::COMP_W-1:0]  comp;
    logic signed [ofc_pkg::DIST_W-1:0]  dterm;
    logic [ofc_pkg::AXIS_W-1:0]         axv;
    logic [ofc_pkg::PLANE_W-1:0]        pw;
    longint cen [3];
    longint ax [3][3];
    longint ext [3];
    longint nrm [3];
    longint plane_d;
    longint radius;
    longint dot;
    bit outside;
    bit span;
    bit hidden;
    ofc_pkg::out_word_t res;
    outside = 1'b0;
    span    = 1'b0;
    hidden  = 1'b0;
    cs = box.center_x;
    cen[0] = longint'(cs);
    cs = box.center_y;
    cen[1] = longint'(cs);
    cs = box.center_z;
    cen[2] = longint'(cs);
    ext[0] = longint'(box.extent_0);
    ext[1] = longint'(box.extent_1);
    ext[2] = longint'(box.extent_2);
    for (int i = 0; i < 3; i++) begin
      axv = (i == 0) ? box.axis_0 : (i == 1) ? box.axis_1 : box.axis_2;
      for (int k = 0; k < 3; k++) begin
        comp = axv[k*ofc_pkg::COMP_W +: ofc_pkg::COMP_W];
        ax[i][k] = longint'(comp);
      end
    end
    for (int p = 0; p < NUM_PLANES; p++) begin
      pw = plane_mirror[p];
      for (int k = 0; k < 3; k++) begin
        comp = pw[k*ofc_pkg::COMP_W +: ofc_pkg::COMP_W];
        nrm[k] = longint'(comp);
      end
      dterm = pw[ofc_pkg::PLANE_W-1 -: ofc_pkg::DIST_W];
      // center term is Q.18, offset scaled up to match, then all to Q.28
      plane_d = nrm[0] * cen[0] + nrm[1] * cen[1] + nrm[2] * cen[2]
                + longint'(dterm) * DIST_SCALE;
      plane_d = plane_d * DIST_SCALE;
      radius = 0;
      for (int i = 0; i < 3; i++) begin
        dot = nrm[0] * ax[i][0] + nrm[1] * ax[i][1] + nrm[2] * ax[i][2];
        radius += ((dot < 0) ? -dot : dot) * ext[i];
      end
      if (plane_d < -radius) outside = 1'b1;
      if (plane_d <= radius) span = 1'b1;
      if (plane_d <= -radius) hidden = 1'b1;
    end
    res.position = outside ? ofc_pkg::POS_OUTSIDE
                 : (span ? ofc_pkg::POS_SPAN : ofc_pkg::POS_INSIDE);
    res.visible  = !hidden;
    return res;
  endfunction

  function automatic logic [ofc_pkg::PLANE_W-1:0] pack_plane(
      input logic signed [ofc_pkg::COMP_W-1:0] a,
      input logic signed [ofc_pkg::COMP_W-1:0] b,
      input logic signed [ofc_pkg::COMP_W-1:0] c,
      input logic signed [ofc_pkg::DIST_W-1:0] d);
    return {d, c, b, a};
  endfunction

  function automatic ofc_pkg::in_word_t make_box(input int cx, input int cy, input int cz,
                                                 input logic [ofc_pkg::AXIS_W-1:0] a0,
                                                 input logic [ofc_pkg::AXIS_W-1:0] a1,
                                                 input logic [ofc_pkg::AXIS_W-1:0] a2,
                                                 input int e0, input int e1, input int e2);
    ofc_pkg::in_word_t b;
    b.center_x = ofc_pkg::COORD_W'(cx);
    b.center_y = ofc_pkg::COORD_W'(cy);
    b.center_z = ofc_pkg::COORD_W'(cz);
    b.axis_0   = a0;
    b.axis_1   = a1;
    b.axis_2   = a2;
    b.extent_0 = ofc_pkg::EXTENT_W'(e0);
    b.extent_1 = ofc_pkg::EXTENT_W'(e1);
    b.extent_2 = ofc_pkg::EXTENT_W'(e2);
    return b;
  endfunction

  function automatic ofc_pkg::in_word_t noise_box();
    logic [287:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(ofc_pkg::in_word_t)-1:0];
  endfunction

  // Box near the origin at the given scale, axes either aligned or tilted.
  function automatic ofc_pkg::in_word_t shaped_box(input int span);
    logic signed [ofc_pkg::COMP_W-1:0] comp [3][3];
    ofc_pkg::in_word_t b;
    bit tilted;
    int rot;
    tilted = $urandom_range(1);
    rot    = $urandom_range(2);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        if (tilted)
          comp[i][k] = ofc_pkg::COMP_W'(int'($urandom_range(2048)) - 1024);
        else if (k == (i + rot) % 3)
          comp[i][k] = $urandom_range(1) ? UNIT_NEG : UNIT_POS;
        else
          comp[i][k] = '0;
      end
    b.center_x = ofc_pkg::COORD_W'(int'($urandom_range(4 * span)) - 2 * span);
    b.center_y = ofc_pkg::COORD_W'(int'($urandom_range(4 * span)) - 2 * span);
    b.center_z = ofc_pkg::COORD_W'(int'($urandom_range(4 * span)) - 2 * span);
    b.axis_0   = {comp[0][2], comp[0][1], comp[0][0]};
    b.axis_1   = {comp[1][2], comp[1][1], comp[1][0]};
    b.axis_2   = {comp[2][2], comp[2][1], comp[2][0]};
    b.extent_0 = ofc_pkg::EXTENT_W'($urandom_range(span));
    b.extent_1 = ofc_pkg::EXTENT_W'($urandom_range(span));
    b.extent_2 = ofc_pkg::EXTENT_W'($urandom_range(span));
    return b;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("MISMATCH at %0t: %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic write_plane(input int idx, input logic [ofc_pkg::PLANE_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx[ofc_pkg::CFG_IDX_W-1:0];
    cfg_data  <= value;
    // indices past the last plane are dropped by the block
    if (idx < NUM_PLANES)
      plane_mirror[idx] = value;
    plane_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_cube(input int half);
    write_plane(REG_NEAR,   pack_plane('0, '0, UNIT_POS, ofc_pkg::DIST_W'(half)));
    write_plane(REG_FAR,    pack_plane('0, '0, UNIT_NEG, ofc_pkg::DIST_W'(half)));
    write_plane(REG_RIGHT,  pack_plane(UNIT_NEG, '0, '0, ofc_pkg::DIST_W'(half)));
    write_plane(REG_LEFT,   pack_plane(UNIT_POS, '0, '0, ofc_pkg::DIST_W'(half)));
    write_plane(REG_TOP,    pack_plane('0, UNIT_NEG, '0, ofc_pkg::DIST_W'(half)));
    write_plane(REG_BOTTOM, pack_plane('0, UNIT_POS, '0, ofc_pkg::DIST_W'(half)));
  endtask

  task automatic queue_box(input ofc_pkg::in_word_t b);
    pending_box.push_back(b);
    boxes_queued++;
  endtask

  task automatic queue_random(input int count, input int span, input int noise_pct);
    for (int n = 0; n < count; n++)
      queue_box(($urandom_range(99) < noise_pct) ? noise_box() : shaped_box(span));
  endtask

  task automatic drain();
    while (results_seen != boxes_queued)
      @(negedge clk);
  endtask

  // Driver: advance to the next word once the current one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || word_taken)) begin
      if (drain_hold && expected_cull.size() == 0)
        drain_hold = 1'b0;
      if (!drain_hold && pending_box.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_word  <= pending_box.pop_front();
        in_valid <= 1'b1;
        sent_count++;
        // hold the next word until the pipe has emptied
        if ($urandom_range(63) == 0 || sent_count % 97 == 40) begin
          drain_hold = 1'b1;
          drain_holds++;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin : check_results
    ofc_pkg::out_word_t want;
    word_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_cull.push_back(cull_classify(in_word));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_cull.size() == 0) begin
          report_mismatch("result with no box pending", int'(out_word.position), -1);
        end else begin
          want = expected_cull.pop_front();
          pos_tally[want.position]++;
          if (!want.visible)
            hidden_tally++;
          if (out_word.position !== want.position)
            report_mismatch("position", int'(out_word.position), int'(want.position));
          if (out_word.visible !== want.visible)
            report_mismatch("visible", int'(out_word.visible), int'(want.visible));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d results seen",
               cycle_count, results_seen, boxes_queued);
      $display("obb_frustum_cull_test test failed");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < NUM_PLANES; p++)
      plane_mirror[p] = '0;
    send_idle_pct  = 19;
    recv_stall_pct = 70;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // planes still at reset: every box spans and is hidden
    @(posedge clk);
    queue_box(make_box(0, 0, 0, AXIS_X, AXIS_Y, AXIS_Z, 256, 256, 256));
    queue_box(noise_box());
    drain();

    load_cube(CUBE_HALF);
    write_plane(REG_SPARE_LO, '1);
    write_plane(REG_SPARE_HI, 64'h0123_4567_89AB_CDEF);
    @(posedge clk);
    queue_box(make_box(0, 0, 0, AXIS_X, AXIS_Y, AXIS_Z, 256, 256, 256));
    // touching a face from inside, then from outside, then just past it
    queue_box(make_box(CUBE_HALF - 512, 0, 0, AXIS_X, AXIS_Y, AXIS_Z, 512, 256, 256));
    queue_box(make_box(CUBE_HALF + 512, 0, 0, AXIS_X, AXIS_Y, AXIS_Z, 512, 256, 256));
    queue_box(make_box(CUBE_HALF + 513, 0, 0, AXIS_X, AXIS_Y, AXIS_Z, 512, 256, 256));
    // outside one plane while straddling another
    queue_box(make_box(-CUBE_HALF - 100, 0, CUBE_HALF, AXIS_X, AXIS_Y, AXIS_Z, 50, 50, 50));
    queue_box(make_box(0, 0, 0, AXIS_X, AXIS_Y, AXIS_Z, EXT_MAX, EXT_MAX, EXT_MAX));
    queue_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, AXIS_X, AXIS_Y, AXIS_Z, 0, 0, 0));
    queue_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, AXIS_X, AXIS_Y, AXIS_Z,
                       EXT_MAX, EXT_MAX, EXT_MAX));
    queue_box(make_box(0, 0, 0, 36'h7FF_7FF_7FF, 36'h7FF_7FF_7FF, 36'h7FF_7FF_7FF,
                       EXT_MAX, EXT_MAX, EXT_MAX));
    queue_box(make_box(100, -100, 0, 36'h800_800_800, 36'h800_800_800, 36'h800_800_800,
                       1000, 1000, 1000));
    queue_box(make_box(0, 0, 0, '1, '1, '1, 4095, 4095, 4095));
    queue_box(make_box(0, 0, 0, '0, '0, '0, EXT_MAX, EXT_MAX, EXT_MAX));
    queue_box(make_box(CUBE_HALF - 300, CUBE_HALF - 300, 0, AXIS_DIAG_A, AXIS_DIAG_B,
                       AXIS_Z, 256, 256, 256));
    queue_box(make_box(0, 0, 0, 36'h000_000_7FF, AXIS_Y, AXIS_Z, 2048, 2048, 2048));
    // a point on the near face: zero distance, zero radius
    queue_box(make_box(0, 0, -CUBE_HALF, AXIS_X, AXIS_Y, AXIS_Z, 0, 0, 0));
    drain();

    // extreme plane contents
    write_plane(REG_NEAR,   pack_plane(12'sh7FF, 12'sh7FF, 12'sh7FF, 28'sh7FF_FFFF));
    write_plane(REG_FAR,    pack_plane(12'sh800, 12'sh800, 12'sh800, 28'sh800_0000));
    write_plane(REG_RIGHT,  '1);
    write_plane(REG_LEFT,   pack_plane(12'sh7FF, 12'sh800, 12'sh001, 28'sh000_0001));
    write_plane(REG_TOP,    {$urandom, $urandom});
    write_plane(REG_BOTTOM, '0);
    @(posedge clk);
    queue_box(make_box(0, 0, 0, '0, '0, '0, 0, 0, 0));
    queue_box(make_box(COORD_MAX, COORD_MIN, COORD_MAX, AXIS_X, AXIS_Y, AXIS_Z,
                       EXT_MAX, 0, EXT_MAX));
    queue_box(noise_box());
    queue_box(noise_box());
    queue_box(noise_box());
    drain();

    // tiny cube: exact touching cases come up often
    load_cube(64);
    @(posedge clk);
    queue_random(RANDOM_PER_PHASE, 64, 20);
    drain();

    send_idle_pct  = 70;
    recv_stall_pct = 19;
    load_cube(1 << 16);
    write_plane(REG_RIGHT, pack_plane(DIAG_NEG, DIAG_NEG, '0, ofc_pkg::DIST_W'(1 << 16)));
    @(posedge clk);
    queue_random(RANDOM_PER_PHASE, 1 << 16, 15);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int p = 0; p < NUM_PLANES; p++)
      write_plane(p, pack_plane(ofc_pkg::COMP_W'($urandom), ofc_pkg::COMP_W'($urandom),
                                ofc_pkg::COMP_W'($urandom),
                                ofc_pkg::DIST_W'(int'($urandom_range(1 << 21)) - (1 << 20))));
    write_plane(REG_SPARE_HI, {$urandom, $urandom});
    @(posedge clk);
    queue_random(RANDOM_PER_PHASE, 1 << 20, 30);
    drain();

    repeat (LATENCY + 16) @(negedge clk);
    if (expected_cull.size() != 0)
      report_mismatch("boxes left without a result", 0, expected_cull.size());

    $display("Culled %0d boxes over %0d plane writes and %0d pipe drains:",
             results_seen, plane_writes, drain_holds);
    $display("  %0d inside, %0d spanning, %0d outside, %0d hidden; %0d mismatches",
             pos_tally[ofc_pkg::POS_INSIDE], pos_tally[ofc_pkg::POS_SPAN],
             pos_tally[ofc_pkg::POS_OUTSIDE], hidden_tally, error_count);
    if (error_count == 0)
      $display("obb_frustum_cull_test test passed");
    else
      $display("obb_frustum_cull_test test failed");
    $finish;
  end

endmodule
